### hw/rtl/lsdbf_pkg.sv
`default_nettype none

package lsdbf_pkg;

  // Longest line that is evaluated, in pixels.
  localparam int unsigned LineWidth = 640;

  // The column counter counts up to LineWidth and then holds.
  localparam int unsigned ColW = $clog2(LineWidth + 1);

  localparam int unsigned GreenW = 6;
  localparam int unsigned PosW   = 10;
  localparam int unsigned SumW   = 16;
  localparam int unsigned PixW   = 16;
  localparam int unsigned CfgW   = 6;

  // Green channel of an RGB565 pixel.
  localparam int unsigned GreenLsb = 5;

  localparam logic [CfgW-1:0] EdgeThresholdRst = CfgW'(15);
  localparam logic [CfgW-1:0] DarkLevelRst     = CfgW'(13);

  typedef enum logic [0:0] {
    CfgEdgeThreshold = 1'b0,
    CfgDarkLevel     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PosW-1:0] start_pos;
    logic [PosW-1:0] end_pos;
    logic [PosW-1:0] middle_pos;
  } blob_t;

endpackage

`default_nettype wire

### hw/rtl/line_scan_dark_blob_finder_core.sv
`default_nettype none
// A blob is registered at the output, or in the skid stage, as its closing pixel is taken.
// Throughput: one pixel transaction per cycle while in_stall_o is low; the edge test, running
// sum and span compare are one short combinational pass between the line state and the result
// register. Reset (asynchronous, active low) clears the green window, column, arm flag, running
// sum and output stages, and loads edge_threshold = 15 and dark_level = 13.

module line_scan_dark_blob_finder_core
  import lsdbf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  // Configuration write port.
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [CfgW-1:0]   cfg_data_i,

  // Pixel input channel.
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [PixW-1:0]   pixel_i,
  input  wire logic              first_of_line_i,

  // Blob result channel.
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [PosW-1:0]        start_pos_o,
  output logic [PosW-1:0]        end_pos_o,
  output logic [PosW-1:0]        middle_pos_o
);

  // Configuration registers.
  logic [CfgW-1:0] edge_thr_q, dark_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_thr_q   <= EdgeThresholdRst;
      dark_level_q <= DarkLevelRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgEdgeThreshold: edge_thr_q   <= cfg_data_i;
        CfgDarkLevel:     dark_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Line state. Window entry 0 holds the oldest green, four pixels back.
  logic [GreenW-1:0] win_q [4];
  logic [ColW-1:0]   col_q;
  logic              armed_q, armed_d;
  logic [PosW-1:0]   edge_pos_q, edge_pos_d;
  logic [SumW-1:0]   sum_q, sum_d;

  logic              in_acc;
  logic [GreenW-1:0] green;
  logic [ColW-1:0]   pos;
  logic [ColW-1:0]   centre;
  logic [PosW-1:0]   centre_pos;
  logic              armed_cur;
  logic              eval;
  logic              rise, fall;
  logic [SumW-1:0]   sum_add;
  logic [PosW-1:0]   span;
  logic [SumW-1:0]   dark_bound;
  logic              hit;
  blob_t             blob;
  logic [PosW:0]     mid_sum;

  assign in_acc = in_valid_i && !in_stall_o;
  assign green  = pixel_i[GreenLsb +: GreenW];

  // A new line restarts the position and drops any open falling edge.
  assign pos       = first_of_line_i ? '0 : col_q;
  assign armed_cur = first_of_line_i ? 1'b0 : armed_q;

  // The derivative is centred two pixels behind the arriving one; centres
  // start at position 2 and stop at LineWidth-3.
  assign eval       = (pos >= ColW'(4)) && (pos <= ColW'(LineWidth - 1));
  assign centre     = pos - ColW'(2);
  assign centre_pos = PosW'(centre);

  // Edge tests on unsigned operands, with the threshold moved to the other side.
  assign rise = ({2'b00, green} >= ({2'b00, win_q[0]} + {2'b00, edge_thr_q}));
  assign fall = ({2'b00, win_q[0]} >= ({2'b00, green} + {2'b00, edge_thr_q}));

  // The centre green is added before the rise test sees the sum.
  assign sum_add    = sum_q + SumW'(win_q[2]);
  assign span       = centre_pos - edge_pos_q;
  assign dark_bound = SumW'(dark_level_q) * SumW'(span);

  assign hit = eval && armed_cur && rise && (sum_add < dark_bound);

  assign mid_sum         = {1'b0, edge_pos_q} + {1'b0, centre_pos};
  assign blob.start_pos  = edge_pos_q;
  assign blob.end_pos    = centre_pos;
  assign blob.middle_pos = mid_sum[PosW:1];

  always_comb begin
    armed_d    = armed_cur;
    edge_pos_d = edge_pos_q;
    sum_d      = sum_q;
    if (eval && armed_cur) begin
      sum_d = sum_add;
      if (hit) begin
        armed_d = 1'b0;
      end
    end
    // A fall at the same centre as a reported rise re-arms right away.
    if (eval && fall) begin
      edge_pos_d = centre_pos;
      sum_d      = '0;
      armed_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        win_q[k] <= '0;
      end
      col_q      <= '0;
      armed_q    <= 1'b0;
      edge_pos_q <= '0;
      sum_q      <= '0;
    end else if (in_acc) begin
      win_q[0]   <= win_q[1];
      win_q[1]   <= win_q[2];
      win_q[2]   <= win_q[3];
      win_q[3]   <= green;
      // Past the end of the line the counter holds and nothing is evaluated.
      col_q      <= (pos < ColW'(LineWidth)) ? pos + ColW'(1) : pos;
      armed_q    <= armed_d;
      edge_pos_q <= edge_pos_d;
      sum_q      <= sum_d;
    end
  end

  // Output register with a skid stage behind it. The input is only stalled
  // when both hold a blob, so a waiting result never blocks the next pixel.
  logic  out_valid_q, out_valid_d;
  logic  skid_valid_q, skid_valid_d;
  blob_t out_q, out_d, skid_q, skid_d;
  logic  push, pop;

  assign push = in_acc && hit;
  assign pop  = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = push;
        skid_d       = blob;
      end else begin
        out_valid_d  = push;
        out_d        = blob;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = blob;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o   = skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign start_pos_o  = out_q.start_pos;
  assign end_pos_o    = out_q.end_pos;
  assign middle_pos_o = out_q.middle_pos;

endmodule

`default_nettype wire

### hw/rtl/lsdbf_checker.sv
`default_nettype none

module lsdbf_checker
  import lsdbf_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_stall_o,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire logic [PosW-1:0] start_pos_o,
  input wire logic [PosW-1:0] end_pos_o,
  input wire logic [PosW-1:0] middle_pos_o
);

  logic [PosW:0] mid_sum;
  assign mid_sum = {1'b0, start_pos_o} + {1'b0, end_pos_o};

  // A stalled result transaction stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  // The midpoint is always the halved sum of both edges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (middle_pos_o == mid_sum[PosW:1]))
    else $error("middle position does not match its edges");

  // The opening falling edge lies strictly before the closing rise.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (start_pos_o < end_pos_o))
    else $error("blob start not before its end");

  // The input is only stalled while a result is waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

endmodule

bind line_scan_dark_blob_finder_core lsdbf_checker u_lsdbf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .start_pos_o  (start_pos_o),
  .end_pos_o    (end_pos_o),
  .middle_pos_o (middle_pos_o)
);

`default_nettype wire

### dv/tb.sv
module tb;
  import lsdbf_pkg::*;

  // A blob is registered at the output, or in its skid stage, as the closing pixel is taken.
  // Between phases a few extra cycles make sure nothing is still in flight.
  localparam int SettleCycles = 8;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HoldCycles   = 300;
  // Cycles without any transaction before the run is declared hung.
  localparam int StallLimit   = 2500;
  // Rough number of pixels to send before the final phase.
  localparam int PixelBudget  = 1060;
  localparam int MaxShown     = 10;

  typedef struct {
    logic [PixW-1:0] pixel;
    logic            first;
  } pixel_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [0:0]       cfg_idx_i = '0;
  logic [CfgW-1:0]  cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [PixW-1:0]  pixel_i = '0;
  logic             first_of_line_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [PosW-1:0]  start_pos_o;
  logic [PosW-1:0]  end_pos_o;
  logic [PosW-1:0]  middle_pos_o;

  line_scan_dark_blob_finder_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .first_of_line_i(first_of_line_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .start_pos_o    (start_pos_o),
    .end_pos_o      (end_pos_o),
    .middle_pos_o   (middle_pos_o)
  );

  always #5 clk_i = ~clk_i;

  // Pixels waiting to be offered, and blobs the scan predicts but the block
  // has not yet delivered.
  pixel_item_t pixel_feed[$];
  blob_t       pending_blobs[$];

  // Shadow of the block's line state and of its two registers.
  logic [GreenW-1:0] green_hist[4];
  logic [ColW-1:0]   col_pos;
  logic              seek_armed;
  logic [PosW-1:0]   fall_pos;
  logic [SumW-1:0]   dark_sum;
  logic [CfgW-1:0]   edge_thr;
  logic [CfgW-1:0]   dark_lvl;

  int  mismatches = 0;
  int  pixels_made = 0;
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;
  bit  calm = 1'b0;
  bit  squeeze_req = 1'b0;

  // Walks one accepted pixel through the line scan. The derivative for the
  // centre two pixels back is formed from the new green and the oldest one in
  // the window. While a falling edge is armed the centre green is added first;
  // a rise is tested before a fall, so with a zero threshold a closed blob is
  // reported and the search re-arms at the very same centre.
  task automatic scan_pixel(input logic [PixW-1:0] pix, input logic first);
    logic [GreenW-1:0] g;
    int                centre;
    int                slope;
    int                span;
    blob_t             found;
    g = pix[GreenLsb +: GreenW];
    if (first) begin
      col_pos = '0;
      seek_armed = 1'b0;
    end
    if (col_pos >= 4 && col_pos <= LineWidth - 1) begin
      centre = int'(col_pos) - 2;
      slope  = int'(g) - int'(green_hist[0]);
      if (seek_armed) begin
        dark_sum = dark_sum + SumW'(green_hist[2]);
        if (slope >= int'(edge_thr)) begin
          span = centre - int'(fall_pos);
          if (int'(dark_sum) < int'(dark_lvl) * span) begin
            found.start_pos  = fall_pos;
            found.end_pos    = PosW'(centre);
            found.middle_pos = PosW'((int'(fall_pos) + centre) >> 1);
            pending_blobs = {pending_blobs, found};
            seek_armed = 1'b0;
          end
        end
      end
      if (slope <= -int'(edge_thr)) begin
        fall_pos   = PosW'(centre);
        dark_sum   = '0;
        seek_armed = 1'b1;
      end
    end
    green_hist[0] = green_hist[1];
    green_hist[1] = green_hist[2];
    green_hist[2] = green_hist[3];
    green_hist[3] = g;
    // Past the end of a line the column holds, so an overlong line only
    // shifts the window until the next line flag.
    if (col_pos < LineWidth) col_pos = col_pos + 1'b1;
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MaxShown) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver. A new transaction is offered only once the previous one has
  // been taken; the payload stays put while the block stalls. Each accepted
  // transaction is handed to the scan right at the edge that takes it.
  // ---------------------------------------------------------------------------
  pixel_item_t next_pixel;
  logic        in_valid_nxt;
  int          in_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      pixel_i         <= '0;
      first_of_line_i <= 1'b0;
    end else begin
      in_valid_nxt = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        scan_pixel(pixel_i, first_of_line_i);
        in_valid_nxt = 1'b0;
      end
      if (!in_valid_nxt) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pixel_feed.size() != 0) begin
          next_pixel = pixel_feed.pop_front();
          pixel_i         <= next_pixel.pixel;
          first_of_line_i <= next_pixel.first;
          in_valid_nxt = 1'b1;
          // Queue up an idle burst that follows this transaction.
          if (!calm && $urandom_range(99) < in_idle_pct) in_gap = $urandom_range(19, 1);
        end
      end
      in_valid_i <= in_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Blob monitor. It checks every accepted result transaction against the
  // oldest predicted blob and drives the result stall: short random bursts,
  // plus one long hold-off on request so that the block backs up and has to
  // stall its pixel input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  blob_t want;
  logic  out_stall_nxt;
  int    out_gap = 0;
  int    hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_blobs.size() == 0) begin
          flag_mismatch($sformatf("unexpected blob start %0d end %0d middle %0d",
                                  start_pos_o, end_pos_o, middle_pos_o));
        end else begin
          want = pending_blobs.pop_front();
          if (start_pos_o !== want.start_pos || end_pos_o !== want.end_pos ||
              middle_pos_o !== want.middle_pos) begin
            flag_mismatch($sformatf(
              "blob expected start %0d end %0d middle %0d, got %0d %0d %0d",
              want.start_pos, want.end_pos, want.middle_pos,
              start_pos_o, end_pos_o, middle_pos_o));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_nxt = 1'b1;
      end else if (squeeze_req && out_valid_o) begin
        squeeze_req   = 1'b0;
        hold_left     = HoldCycles;
        out_stall_nxt = 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall_nxt = 1'b1;
      end else begin
        out_stall_nxt = 1'b0;
        if (!calm && $urandom_range(99) < out_idle_pct) out_gap = $urandom_range(19, 1);
      end
      out_stall_i <= out_stall_nxt;
    end
  end

  // Watchdog: any transaction on either channel or a register write resets
  // the count; a long silence means the block or the run is stuck.
  int quiet = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= StallLimit) begin
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d blobs outstanding",
               $realtime, quiet, pending_blobs.size());
      $display("** line_scan_dark_blob_finder_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Red and blue are random so that every pixel bit toggles; only green counts.
  task automatic push_green(input int g, input bit first);
    pixel_item_t item;
    item.pixel = PixW'($urandom);
    item.pixel[GreenLsb +: GreenW] = GreenW'(g);
    item.first = first;
    pixel_feed = {pixel_feed, item};
    pixels_made++;
  endtask

  task automatic push_raw(input logic [PixW-1:0] pix, input bit first);
    pixel_item_t item;
    item.pixel = pix;
    item.first = first;
    pixel_feed = {pixel_feed, item};
    pixels_made++;
  endtask

  // A scene line: bright stretches alternating with dark dips. Levels follow
  // the current registers so that most dips have edges steep enough and a
  // mean dark enough to count as blobs. A few pixels are pure noise.
  task automatic add_scene_line(input int len, input bit lead_flag, input int max_run);
    int n;
    int run;
    int lit;
    int dim;
    int lo;
    int g;
    bit dipping;
    n = 0;
    dipping = 1'b0;
    lit = $urandom_range(63, 40);
    dim = 0;
    while (n < len) begin
      if (dipping) begin
        dim = (dark_lvl > 0) ? $urandom_range(int'(dark_lvl) - 1, 0) : 0;
        lo  = dim + int'(edge_thr);
        if (lo > 63) lo = 63;
        lit = $urandom_range(63, lo);
        run = $urandom_range(max_run + 8, 3);
      end else begin
        run = $urandom_range(max_run, 2);
      end
      repeat (run) begin
        if (n < len) begin
          g = dipping ? dim : lit;
          if ($urandom_range(15) == 0) g = $urandom_range(63);
          push_green(g, lead_flag && n == 0);
          n++;
        end
      end
      dipping = !dipping;
    end
  endtask

  // Noise: fully random pixels, with the line flag now and then in mid-line.
  task automatic add_noise_line(input int len);
    repeat (len) push_raw(PixW'($urandom), $urandom_range(31) == 0);
  endtask

  // A mix of lines: mostly well-formed scenes, some noise, and some broken
  // ones with very short runs or a missing line flag.
  task automatic add_line_mix(input int budget);
    int target;
    int pick;
    target = pixels_made + budget;
    while (pixels_made < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        add_scene_line($urandom_range(60, 8), 1'b1, 12);
      end else if (pick < 85) begin
        add_noise_line($urandom_range(40, 4));
      end else begin
        add_scene_line($urandom_range(40, 4), $urandom_range(1), 3);
      end
    end
  endtask

  // Register writes are issued only with the block idle, so the shadow copy can
  // change as soon as the write is driven, ahead of the block's register.
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == CfgEdgeThreshold) edge_thr = value;
    else dark_lvl = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every pixel has been taken and every predicted blob has come
  // out, then a few more cycles in case the last pixel is still in flight.
  task automatic settle();
    do @(posedge clk_i);
    while (pixel_feed.size() != 0 || in_valid_i || pending_blobs.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic pick_idling();
    int rates[4];
    rates = '{0, 5, 25, 50};
    in_idle_pct  = rates[$urandom_range(3)];
    out_idle_pct = rates[$urandom_range(3)];
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  int phase;
  int thr_pick;
  int dark_pick;

  initial begin
    foreach (green_hist[k]) green_hist[k] = '0;
    col_pos    = '0;
    seek_armed = 1'b0;
    fall_pos   = '0;
    dark_sum   = '0;
    edge_thr   = EdgeThresholdRst;
    dark_lvl   = DarkLevelRst;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening with the reset register values. The very first pixel
    // carries no line flag, yet it must be taken as position zero. A hard
    // bright-to-dark-to-bright dip follows, built from the all-ones and
    // all-zeros pixels among others, so the first blob closes early.
    pick_idling();
    push_raw('1, 1'b0);
    repeat (4) push_green(63, 1'b0);
    push_raw('0, 1'b0);
    push_raw(16'hF81F, 1'b0);
    repeat (3) push_green(0, 1'b0);
    repeat (4) push_green(63, 1'b0);
    // Two line flags in a row, then a line that ends while a fall is armed;
    // the next flag must disarm it before the bright pixels that follow.
    push_green(63, 1'b1);
    push_green(63, 1'b1);
    repeat (2) push_green(63, 1'b0);
    repeat (3) push_green(0, 1'b0);
    push_green(0, 1'b1);
    repeat (4) push_green(63, 1'b0);
    settle();

    phase = 1;
    forever begin
      case (phase)
        1: begin thr_pick = 0;  dark_pick = 63; end
        2: begin thr_pick = 63; dark_pick = 0;  end
        3: begin thr_pick = $urandom_range(20, 12); dark_pick = $urandom_range(45, 30); end
        4: begin thr_pick = 63; dark_pick = 63; end
        5: begin thr_pick = 1;  dark_pick = 1;  end
        default: begin
          thr_pick  = $urandom_range(40, 0);
          dark_pick = $urandom_range(63, 5);
        end
      endcase
      write_reg(CfgEdgeThreshold, CfgW'(thr_pick));
      write_reg(CfgDarkLevel, CfgW'(dark_pick));
      pick_idling();
      if (phase == 3) begin
        // One full-length line running past the end, plus the long hold-off
        // on the result side while pixels keep coming.
        squeeze_req = 1'b1;
        add_scene_line($urandom_range(720, 660), 1'b1, 12);
      end else begin
        add_line_mix(50);
      end
      settle();
      phase++;
      if (phase > 6 && pixels_made >= PixelBudget) break;
      if (phase > 40) break;
    end

    // Final stretch runs flat out on both sides.
    calm = 1'b1;
    write_reg(CfgEdgeThreshold, CfgW'($urandom_range(25, 8)));
    write_reg(CfgDarkLevel, CfgW'($urandom_range(50, 20)));
    add_line_mix(50);
    settle();

    if (mismatches == 0) begin
      $display("** line_scan_dark_blob_finder_core: PASSED **");
    end else begin
      $display("** line_scan_dark_blob_finder_core: FAILED **");
    end
    $finish;
  end

endmodule
